// File: rtl/tkiq_pkg.sv
// shared types, constants and helper functions for the terminal key input queue
`default_nettype none

package tkiq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int PTR_W       = ADDR_W + 1;

  // results of one item, done result included
  localparam int MAX_RESULTS = 33;
  localparam int RES_CAP     = MAX_RESULTS - 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // special bytes
  localparam logic [7:0] CTRL_C    = 8'h03;
  localparam logic [7:0] CTRL_Z    = 8'h1A;
  localparam logic [7:0] ESC       = 8'h1B;
  localparam logic [7:0] CTRL_MASK = 8'h1F;

  // extended scancodes
  localparam logic [7:0] SC_HOME  = 8'h47;
  localparam logic [7:0] SC_UP    = 8'h48;
  localparam logic [7:0] SC_LEFT  = 8'h4B;
  localparam logic [7:0] SC_RIGHT = 8'h4D;
  localparam logic [7:0] SC_END   = 8'h4F;
  localparam logic [7:0] SC_DOWN  = 8'h50;
  localparam logic [7:0] SC_DEL   = 8'h53;

  // operation codes
  typedef enum logic [2:0] {
    FUNC_KEY     = 3'd0,
    FUNC_RAW     = 3'd1,
    FUNC_READ    = 3'd2,
    FUNC_SERVICE = 3'd3,
    FUNC_FLUSH   = 3'd4
  } func_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_INTR    = 2'd1,
    KIND_SUSPEND = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_FOREGROUND = 1'd0,
    CFG_KEYBOARD   = 1'd1
  } cfg_index_t;

  // input item
  typedef struct packed {
    logic [2:0] func;
    logic       key_pressed;
    logic [7:0] key_char;
    logic       control_held;
    logic       key_extended;
    logic [7:0] scancode;
    logic [7:0] data_byte;
    logic [7:0] read_limit;
  } item_t;

  // result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        signal_sent;
    logic        last;
    logic [2:0]  appended;
    logic [5:0]  queued;
    logic [63:0] delivered_total;
    logic [63:0] discarded_total;
    logic [63:0] translated_total;
    logic [63:0] intercepted_total;
    logic [63:0] signals_total;
  } result_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH,
    ST_SFETCH,
    ST_SEVAL,
    ST_EFETCH,
    ST_EMIT,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic push;
    logic sfetch;
    logic seval;
    logic efetch;
    logic emit;
    logic done_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic push_nz;
    logic scan_go;
    logic push_last;
    logic scan_more;
    logic scan_nz;
    logic emit_last;
  } status_t;

  // escape sequence length for an extended scancode, zero if none
  function automatic logic [2:0] seq_len(input logic [7:0] sc);
    logic [2:0] len;
    case (sc)
      SC_UP, SC_DOWN, SC_RIGHT, SC_LEFT, SC_HOME, SC_END: len = 3'd3;
      SC_DEL:  len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // one byte of the escape sequence
  function automatic logic [7:0] seq_byte(input logic [7:0] sc, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = ESC;
      2'd1:    b = "[";
      2'd2: begin
        case (sc)
          SC_UP:    b = "A";
          SC_DOWN:  b = "B";
          SC_RIGHT: b = "C";
          SC_LEFT:  b = "D";
          SC_HOME:  b = "H";
          SC_END:   b = "F";
          default:  b = "3";
        endcase
      end
      default: b = "~";
    endcase
    return b;
  endfunction

  // control reduces a letter to its low five bits
  function automatic logic [7:0] ctrl_char(input logic [7:0] ch, input logic ctrl);
    logic is_letter;
    is_letter = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    return (ctrl && is_letter) ? (ch & CTRL_MASK) : ch;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tkiq_ctrl.sv
// controller state machine sequencing push, scan and emit phases
`default_nettype none

module tkiq_ctrl
  import tkiq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (st.push_nz) state_next = ST_PUSH;
        else if (st.scan_go) state_next = ST_SFETCH;
        else state_next = ST_DONE;
      end
      ST_PUSH: begin
        if (st.push_last) state_next = ST_DONE;
      end
      ST_SFETCH: state_next = ST_SEVAL;
      ST_SEVAL: begin
        if (st.scan_more) state_next = ST_SFETCH;
        else if (st.scan_nz) state_next = ST_EFETCH;
        else state_next = ST_DONE;
      end
      ST_EFETCH: state_next = ST_EMIT;
      ST_EMIT: begin
        if (st.out_free) state_next = st.emit_last ? ST_DONE : ST_EFETCH;
      end
      ST_DONE: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DECODE: cmd.decode = 1'b1;
      ST_PUSH:   cmd.push   = 1'b1;
      ST_SFETCH: cmd.sfetch = 1'b1;
      ST_SEVAL:  cmd.seval  = 1'b1;
      ST_EFETCH: cmd.efetch = 1'b1;
      ST_EMIT:   cmd.emit   = st.out_free;
      ST_DONE:   cmd.done_load = st.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/tkiq_dp.sv
// datapath: byte store, pointers, counters, configuration and output register
`default_nettype none

module tkiq_dp
  import tkiq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire item_t       in_data,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        out_stall,
  output logic             out_valid,
  output result_t          out_data,
  input  wire cmd_t        cmd,
  output status_t          st
);

  logic [7:0]       mem [QUEUE_DEPTH];
  logic [7:0]       mem_q;
  item_t            item;
  logic [PTR_W-1:0] wr_ptr, rd_ptr, scan_ptr;
  logic [63:0]      delivered_cnt, discarded_cnt, translated_cnt, intercepted_cnt, signals_cnt;
  logic [63:0]      fg_group;
  logic             kb_attached;
  logic [2:0]       push_len;
  logic [1:0]       push_idx;
  logic [2:0]       appended;
  logic [CNT_W-1:0] n_int, n_del, emit_idx;
  logic             mode_del;

  logic [PTR_W-1:0] held, scan_held;
  logic             full;
  logic [2:0]       key_len;
  logic             is_seq;
  logic [7:0]       push_byte;
  logic [CNT_W-1:0] results;
  logic             avail, is_sig, is_read, take_int, take_del;
  logic             fg_nz;
  logic [ADDR_W-1:0] rd_addr;

  // occupancy
  assign held      = wr_ptr - rd_ptr;
  assign scan_held = wr_ptr - scan_ptr;
  assign full      = (held == PTR_W'(QUEUE_DEPTH));
  assign fg_nz     = (fg_group != '0);

  // bytes a key event or raw byte will append
  always_comb begin
    key_len = 3'd0;
    is_seq  = 1'b0;
    if (item.func == FUNC_KEY) begin
      if (kb_attached && item.key_pressed) begin
        if (item.key_char != 8'd0) begin
          key_len = 3'd1;
        end else if (item.key_extended) begin
          key_len = seq_len(item.scancode);
          is_seq  = (key_len != 3'd0);
        end
      end
    end else if (item.func == FUNC_RAW) begin
      key_len = 3'd1;
    end
  end

  // byte at the current push position
  always_comb begin
    if (item.func == FUNC_RAW) push_byte = item.data_byte;
    else if (item.key_char != 8'd0) push_byte = ctrl_char(item.key_char, item.control_held);
    else push_byte = seq_byte(item.scancode, push_idx);
  end

  // scan decisions on the fetched head byte
  assign results  = n_int + n_del;
  assign avail    = (scan_held != '0) && (results < CNT_W'(RES_CAP));
  assign is_sig   = (mem_q == CTRL_C) || (mem_q == CTRL_Z);
  assign is_read  = (item.func == FUNC_READ);
  assign take_int = !mode_del && avail && is_sig;
  assign take_del = is_read && avail && !is_sig && (9'(n_del) < 9'(item.read_limit));

  // status to controller
  always_comb begin
    st.out_free  = !out_valid || !out_stall;
    st.push_nz   = (key_len != 3'd0);
    st.scan_go   = (is_read && item.read_limit != 8'd0) || (item.func == FUNC_SERVICE);
    st.push_last = ({1'b0, push_idx} + 3'd1 == push_len);
    st.scan_more = take_int || take_del;
    st.scan_nz   = (results != '0);
    st.emit_last = (emit_idx + CNT_W'(1) == results);
  end

  // byte store write and registered read
  assign rd_addr = cmd.efetch ? rd_ptr[ADDR_W-1:0] : scan_ptr[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[wr_ptr[ADDR_W-1:0]] <= push_byte;
    end
    if (cmd.sfetch || cmd.efetch) begin
      mem_q <= mem[rd_addr];
    end
  end

  // control state: pointers, counters, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      delivered_cnt   <= '0;
      discarded_cnt   <= '0;
      translated_cnt  <= '0;
      intercepted_cnt <= '0;
      signals_cnt     <= '0;
      fg_group        <= '0;
      kb_attached     <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FOREGROUND: fg_group    <= cfg_data;
          CFG_KEYBOARD:   kb_attached <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.decode) begin
        if (is_seq) translated_cnt <= translated_cnt + 64'd1;
        if (item.func == FUNC_FLUSH) rd_ptr <= wr_ptr;
      end
      if (cmd.push) begin
        if (full) discarded_cnt <= discarded_cnt + 64'd1;
        else wr_ptr <= wr_ptr + PTR_W'(1);
      end
      // commit totals once the scan has settled
      if (cmd.seval && !(take_int || take_del)) begin
        delivered_cnt   <= delivered_cnt + 64'(n_del);
        intercepted_cnt <= intercepted_cnt + 64'(n_int);
        if (fg_nz) signals_cnt <= signals_cnt + 64'(n_int);
      end
      if (cmd.emit) rd_ptr <= rd_ptr + PTR_W'(1);
    end
  end

  // per item working registers
  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.decode) begin
      push_len <= key_len;
      push_idx <= '0;
      appended <= '0;
      n_int    <= '0;
      n_del    <= '0;
      emit_idx <= '0;
      mode_del <= 1'b0;
      scan_ptr <= rd_ptr;
    end
    if (cmd.push) begin
      push_idx <= push_idx + 2'd1;
      if (!full) appended <= appended + 3'd1;
    end
    if (cmd.seval) begin
      if (take_int) begin
        n_int    <= n_int + CNT_W'(1);
        scan_ptr <= scan_ptr + PTR_W'(1);
      end else if (take_del) begin
        n_del    <= n_del + CNT_W'(1);
        scan_ptr <= scan_ptr + PTR_W'(1);
        mode_del <= 1'b1;
      end
    end
    if (cmd.emit) emit_idx <= emit_idx + CNT_W'(1);
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.done_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.done_load) begin
      out_data.delivered_total   <= delivered_cnt;
      out_data.discarded_total   <= discarded_cnt;
      out_data.translated_total  <= translated_cnt;
      out_data.intercepted_total <= intercepted_cnt;
      out_data.signals_total     <= signals_cnt;
      if (cmd.done_load) begin
        out_data.kind        <= KIND_DONE;
        out_data.out_byte    <= 8'd0;
        out_data.signal_sent <= 1'b0;
        out_data.last        <= 1'b1;
        out_data.appended    <= appended;
        out_data.queued      <= 6'(held);
      end else begin
        out_data.last     <= 1'b0;
        out_data.appended <= 3'd0;
        out_data.queued   <= 6'd0;
        if (emit_idx < n_int) begin
          out_data.kind        <= (mem_q == CTRL_C) ? KIND_INTR : KIND_SUSPEND;
          out_data.out_byte    <= 8'd0;
          out_data.signal_sent <= fg_nz;
        end else begin
          out_data.kind        <= KIND_BYTE;
          out_data.out_byte    <= mem_q;
          out_data.signal_sent <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/terminal_key_input_queue.sv
// top level of the terminal key input queue
//
// Input channel in_valid/in_stall/in_data carries one operation: key event,
// raw byte, read, service or flush. Output channel out_valid/out_stall/out_data
// returns that operation's results: signals and delivered bytes, then one done
// result with last set. Counter totals on every result are those after the
// whole operation. cfg_we/cfg_index/cfg_data write the foreground group and
// keyboard attach registers; the user must write them only while the block is
// idle, which the block itself does not enforce.
// Sequence: one operation is worked at a time. A decode step follows the
// transfer, then a push for each byte of the key or raw byte (up to 4), or for
// a read or service a scan of the queue head that fetches and evaluates each
// byte taken, plus a final fetch that ends the scan, then a fetch and an emit
// for each result, then the done result.
// The next operation is taken as soon as the done result sits in the output
// register. When the receiver stalls, the output register holds and the
// sequencer waits. Reset empties the queue, clears the counters and the
// foreground group, and attaches the keyboard; no clearing pass is needed.
`default_nettype none

module terminal_key_input_queue
  import tkiq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire item_t       in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output result_t          out_data,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  // sequencer
  tkiq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // queue and counters
  tkiq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire
